FILE: hw/rtl/cti_pkg.sv
// ----------------------------------------------------------------------------
// cti_pkg: shared types and constants of the cubic trajectory interpolator
// Transaction structs, status codes and register indexes.
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned VEL_W     = 48;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = 2'd1;

  // window status codes
  localparam logic [STAT_W-1:0] ST_INSIDE = 2'd0;
  localparam logic [STAT_W-1:0] ST_BEFORE = 2'd1;
  localparam logic [STAT_W-1:0] ST_AFTER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic        [TIME_W-1:0] now_time;
    logic signed [POS_W-1:0]  from_position;
    logic signed [POS_W-1:0]  to_position;
  } cti_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position_out;
    logic signed [VEL_W-1:0]  velocity_out;
    logic        [STAT_W-1:0] window_status;
  } cti_out_t;

endpackage

FILE: hw/rtl/cti_div_pipe.sv
// ----------------------------------------------------------------------------
// cti_div_pipe: pipelined restoring divider
// One quotient bit per stage; the starting remainder must be below the
// divisor. Side data travels alongside, all stages move on en_i.
// ----------------------------------------------------------------------------
module cti_div_pipe
  import cti_pkg::*;
#(
  parameter int unsigned QW = 24,
  parameter int unsigned SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [TIME_W-1:0] rem_i,
  input  logic [QW-1:0]     num_i,
  input  logic [TIME_W-1:0] div_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quot_o,
  output logic [SW-1:0]     side_o
);

  logic [TIME_W-1:0] rem_q  [QW];
  logic [QW-1:0]     num_q  [QW];
  logic [QW-1:0]     quo_q  [QW];
  logic [SW-1:0]     side_q [QW];
  logic              vld_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [TIME_W-1:0] src_rem;
    logic [QW-1:0]     src_num;
    logic [QW-1:0]     src_quo;
    logic [SW-1:0]     src_side;
    logic              src_vld;
    logic [TIME_W:0]   r2;
    logic [TIME_W:0]   diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign src_rem  = rem_i;
      assign src_num  = num_i;
      assign src_quo  = '0;
      assign src_side = side_i;
      assign src_vld  = valid_i;
    end else begin : g_next
      assign src_rem  = rem_q[j-1];
      assign src_num  = num_q[j-1];
      assign src_quo  = quo_q[j-1];
      assign src_side = side_q[j-1];
      assign src_vld  = vld_q[j-1];
    end

    // remainder < divisor, so r2 - div fits: bit TIME_W is the borrow
    assign r2   = {src_rem, src_num[QW-1]};
    assign diff = r2 - {1'b0, div_i};
    assign ge   = ~diff[TIME_W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[TIME_W-1:0] : r2[TIME_W-1:0];
        num_q[j]  <= {src_num[QW-2:0], 1'b0};
        quo_q[j]  <= {src_quo[QW-2:0], ge};
        side_q[j] <= src_side;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

FILE: hw/rtl/cubic_trajectory_interpolator_top.sv
// ----------------------------------------------------------------------------
// cubic_trajectory_interpolator_top: cubic point-to-point joint trajectory
// Zero end velocity blend s = 3tau^2 - 2tau^3 with its per-tick rate.
// ----------------------------------------------------------------------------
// Each input transaction carries a time tick and one joint's start and end
// positions (signed Q16.16); the window comes from the start_time/end_time
// registers. The block returns the interpolated position (Q16.16) and the
// velocity per tick (Q16.32, saturated to 48 bits). Time outside the window
// clamps tau to 0 or 1 and reports status 1 or 2; end_time <= start_time
// returns from_position, zero velocity and status 3. Throughput is one
// transaction per cycle while in_stall_o is low. The pipeline has three entry
// stages, one tau divider stage per fraction bit, five arithmetic stages, a
// 48-stage velocity divider (one quotient bit per stage), a saturation stage
// and the output register. The pipeline moves as a whole; a two-entry
// output buffer (output register plus skid register) absorbs a stalled
// output, and in_stall_o is asserted only while the skid register is full.
// Write the registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
module cubic_trajectory_interpolator_top
  import cti_pkg::*;
#(
  parameter int unsigned TAU_FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cti_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cti_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i
);

  localparam int unsigned F  = TAU_FRAC_BITS;
  localparam int unsigned TW = F + 1;        // tau, Q1.F
  localparam int unsigned KW = F + 2;        // 3 - 2tau
  localparam int unsigned PW = F + 33;       // magnitude products
  localparam int unsigned NW = VEL_W + 1;    // velocity dividend

  localparam logic [TW-1:0]    TAU_ONE     = {1'b1, {F{1'b0}}};
  localparam logic [KW-1:0]    THREE_ONE   = {2'b11, {F{1'b0}}};
  localparam logic [VEL_W-1:0] VEL_POS_LIM = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_NEG_LIM = {1'b1, {(VEL_W-1){1'b0}}};

  typedef struct packed {
    logic [POS_W-1:0]  p0;
    logic [POS_W-1:0]  mag;
    logic              neg;
    logic [STAT_W-1:0] status;
    logic              full;
  } side1_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic              neg;
    logic [STAT_W-1:0] status;
    logic              ovf;
  } side2_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] start_q, end_q;
  logic [TIME_W-1:0] dur_w;
  logic              empty_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= TIME_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_TIME: start_q <= cfg_data_i;
        REG_END_TIME:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the user keeps these static while transactions are in flight; not enforced here
  assign dur_w   = end_q - start_q;
  assign empty_w = (end_q <= start_q);

  // whole pipeline advances unless the skid register holds a result
  logic pipe_en;
  logic skid_vld_q;

  assign pipe_en    = ~skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // --------------------------------------------------------------------------
  // S1: input register
  // --------------------------------------------------------------------------
  logic    s1_vld_q;
  cti_in_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // S2: window check, elapsed ticks, position difference
  // --------------------------------------------------------------------------
  logic              before_w, after_w;
  logic [STAT_W-1:0] status_d;
  logic [TIME_W-1:0] elap_d;
  logic [POS_W:0]    diff_d;

  logic              s2_vld_q;
  logic [STAT_W-1:0] s2_status_q;
  logic [TIME_W-1:0] s2_elap_q;
  logic [POS_W:0]    s2_diff_q;
  logic [POS_W-1:0]  s2_p0_q;

  assign before_w = s1_q.now_time < start_q;
  assign after_w  = s1_q.now_time > end_q;

  always_comb begin
    if (empty_w) begin
      status_d = ST_EMPTY;
    end else if (before_w) begin
      status_d = ST_BEFORE;
    end else if (after_w) begin
      status_d = ST_AFTER;
    end else begin
      status_d = ST_INSIDE;
    end
    if (before_w) begin
      elap_d = '0;
    end else if (after_w) begin
      elap_d = dur_w;
    end else begin
      elap_d = s1_q.now_time - start_q;
    end
  end

  assign diff_d = {s1_q.to_position[POS_W-1], s1_q.to_position}
                - {s1_q.from_position[POS_W-1], s1_q.from_position};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_status_q <= status_d;
      s2_elap_q   <= elap_d;
      s2_diff_q   <= diff_d;
      s2_p0_q     <= s1_q.from_position;
    end
  end

  // --------------------------------------------------------------------------
  // S3: magnitude and sign of the move, tau = 1 detect
  // --------------------------------------------------------------------------
  logic [POS_W:0]    mag_w;
  logic              s3_vld_q;
  side1_t            s3_side_q;
  logic [TIME_W-1:0] s3_elap_q;

  assign mag_w = s2_diff_q[POS_W] ? (~s2_diff_q + 1'b1) : s2_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_side_q.p0     <= s2_p0_q;
      s3_side_q.mag    <= mag_w[POS_W-1:0];
      s3_side_q.neg    <= s2_diff_q[POS_W];
      s3_side_q.status <= s2_status_q;
      s3_side_q.full   <= (s2_elap_q == dur_w);
      s3_elap_q        <= s2_elap_q;
    end
  end

  // --------------------------------------------------------------------------
  // tau divider: elapsed * 2^F / duration, fraction bits only
  // --------------------------------------------------------------------------
  logic         d1_vld;
  logic [F-1:0] d1_quot;
  side1_t       d1_side;

  cti_div_pipe #(
    .QW (F),
    .SW ($bits(side1_t))
  ) u_tau_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s3_vld_q),
    .rem_i   (s3_elap_q),
    .num_i   ('0),
    .div_i   (dur_w),
    .side_i  (s3_side_q),
    .valid_o (d1_vld),
    .quot_o  (d1_quot),
    .side_o  (d1_side)
  );

  // --------------------------------------------------------------------------
  // T: tau, 1 - tau, 3 - 2tau
  // --------------------------------------------------------------------------
  logic [TW-1:0] tau_w;
  logic          t_vld_q;
  logic [TW-1:0] t_tau_q, t_omt_q;
  logic [KW-1:0] t_k_q;
  side1_t        t_side_q;

  assign tau_w = d1_side.full ? TAU_ONE : {1'b0, d1_quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
    end else if (pipe_en) begin
      t_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t_tau_q  <= tau_w;
      t_omt_q  <= TAU_ONE - tau_w;
      t_k_q    <= THREE_ONE - {tau_w, 1'b0};
      t_side_q <= d1_side;
    end
  end

  // --------------------------------------------------------------------------
  // M1: tau^2 and tau(1 - tau)
  // --------------------------------------------------------------------------
  logic            m1_vld_q;
  logic [2*TW-1:0] m1_t2f_q, m1_g_q;
  logic [KW-1:0]   m1_k_q;
  side1_t          m1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (pipe_en) begin
      m1_vld_q <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m1_t2f_q  <= t_tau_q * t_tau_q;
      m1_g_q    <= t_tau_q * t_omt_q;
      m1_k_q    <= t_k_q;
      m1_side_q <= t_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // M2: s = t2 * (3 - 2tau), w = 6 tau (1 - tau)
  // --------------------------------------------------------------------------
  logic [TW-1:0]      t2_w;
  logic [2*TW-1:0]    g3_w;
  logic               m2_vld_q;
  logic [TW+KW-1:0]   m2_sf_q;
  logic [TW-1:0]      m2_w_q;
  side1_t             m2_side_q;

  assign t2_w = m1_t2f_q[2*F:F];
  assign g3_w = m1_g_q + {m1_g_q[2*TW-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (pipe_en) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m2_sf_q   <= t2_w * m1_k_q;
      m2_w_q    <= g3_w[2*F-1:F-1];
      m2_side_q <= m1_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // M3: scale both blends by the move magnitude
  // --------------------------------------------------------------------------
  logic [TW-1:0] s_w;
  logic          m3_vld_q;
  logic [PW-1:0] m3_pp_q, m3_vp_q;
  side1_t        m3_side_q;

  assign s_w = m2_sf_q[2*F:F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_vld_q <= 1'b0;
    end else if (pipe_en) begin
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m3_pp_q   <= m2_side_q.mag * s_w;
      m3_vp_q   <= m2_side_q.mag * m2_w_q;
      m3_side_q <= m2_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // M4: final position, velocity dividend at Q.32 (Q.F blend times magnitude in Q.16)
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] pmag_w;
  logic [POS_W:0]   pos_w;
  logic [PW+15:0]   vext_w;
  logic [NW-1:0]    vnum_w;
  logic             m4_vld_q;
  logic [VEL_W-1:0] m4_num_q;
  logic             m4_hi_q;
  side2_t           m4_side_q;

  assign pmag_w = m3_pp_q[F+POS_W-1:F];
  assign pos_w  = m3_side_q.neg
                ? ({m3_side_q.p0[POS_W-1], m3_side_q.p0} - {1'b0, pmag_w})
                : ({m3_side_q.p0[POS_W-1], m3_side_q.p0} + {1'b0, pmag_w});
  assign vext_w = {m3_vp_q, 16'd0};
  assign vnum_w = vext_w[F+NW-1:F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4_vld_q <= 1'b0;
    end else if (pipe_en) begin
      m4_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m4_num_q         <= vnum_w[VEL_W-1:0];
      m4_hi_q          <= vnum_w[VEL_W];
      m4_side_q.pos    <= (m3_side_q.status == ST_EMPTY) ? m3_side_q.p0 : pos_w[POS_W-1:0];
      m4_side_q.neg    <= m3_side_q.neg;
      m4_side_q.status <= m3_side_q.status;
      // quotient reaches 2^48 only for a top dividend bit over a unit window
      m4_side_q.ovf    <= vnum_w[VEL_W] && (dur_w == TIME_W'(1));
    end
  end

  // --------------------------------------------------------------------------
  // velocity divider: dividend / duration, 48 quotient bits
  // --------------------------------------------------------------------------
  logic             d2_vld;
  logic [VEL_W-1:0] d2_quot;
  side2_t           d2_side;

  cti_div_pipe #(
    .QW (VEL_W),
    .SW ($bits(side2_t))
  ) u_vel_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (m4_vld_q),
    .rem_i   ({{(TIME_W-1){1'b0}}, m4_hi_q & ~m4_side_q.ovf}),
    .num_i   (m4_num_q),
    .div_i   (dur_w),
    .side_i  (m4_side_q),
    .valid_o (d2_vld),
    .quot_o  (d2_quot),
    .side_o  (d2_side)
  );

  // --------------------------------------------------------------------------
  // SAT: clamp magnitude to the signed 48-bit range
  // --------------------------------------------------------------------------
  logic [VEL_W-1:0] lim_w;
  logic             sat_vld_q;
  logic [VEL_W-1:0] sat_vmag_q;
  side2_t           sat_side_q;

  assign lim_w = d2_side.neg ? VEL_NEG_LIM : VEL_POS_LIM;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_vld_q <= 1'b0;
    end else if (pipe_en) begin
      sat_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sat_vmag_q <= (d2_side.ovf || (d2_quot > lim_w)) ? lim_w : d2_quot;
      sat_side_q <= d2_side;
    end
  end

  // --------------------------------------------------------------------------
  // result assembly, output register and skid register
  // --------------------------------------------------------------------------
  cti_out_t pipe_res;
  logic     out_vld_q, out_vld_d;
  cti_out_t out_q, out_d;
  logic     skid_vld_d;
  cti_out_t skid_q, skid_d;

  always_comb begin
    pipe_res.position_out  = sat_side_q.pos;
    pipe_res.window_status = sat_side_q.status;
    if (sat_side_q.status == ST_EMPTY) begin
      pipe_res.velocity_out = '0;
    end else if (sat_side_q.neg) begin
      pipe_res.velocity_out = ~sat_vmag_q + 1'b1;
    end else begin
      pipe_res.velocity_out = sat_vmag_q;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = sat_vld_q;
        out_d     = pipe_res;
      end
    end else if (sat_vld_q && pipe_en) begin
      skid_vld_d = 1'b1;
      skid_d     = pipe_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // skid only fills behind a held output transaction
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  // a frozen pipeline keeps its last stage
  a_frozen_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(sat_vld_q))
    else $error("pipeline moved while frozen");

  // empty window never reports motion
  a_empty_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.window_status == ST_EMPTY)) |-> (out_q.velocity_out == '0))
    else $error("nonzero velocity on empty window");

  // a held output transaction drains the skid register when released
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_stall_i) |=> !skid_vld_q)
    else $error("skid register not drained");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cubic trajectory interpolator
// Randomized and directed joint moves are streamed through the block. Each
// result is checked against an in-bench trajectory calculation that is run
// under the window registers active at acceptance time.
// ----------------------------------------------------------------------------
module tb_top
  import cti_pkg::*;
();

  localparam int unsigned TAU_F   = 24;
  localparam int unsigned LATENCY = TAU_F + 58;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cti_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cti_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;

  // bench copy of the window registers (reset values)
  logic [TIME_W-1:0] win_start = '0;
  logic [TIME_W-1:0] win_end   = 32'd1;

  cti_in_t  move_q[$];      // moves waiting to be offered
  cti_out_t sample_q[$];    // expected trajectory samples, oldest first
  int       n_errors = 0;
  int       in_gap   = 0;
  int       out_gap  = 0;
  bit       idle_on  = 1'b1;  // random idling enable, both sides
  int       hold_req = 0;     // bumped to ask the receiver for a long hold-off
  int       hold_ack = 0;
  int       hold_cnt = 0;

  always #6 clk = ~clk;

  cubic_trajectory_interpolator_top #(.TAU_FRAC_BITS(TAU_F)) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Trajectory sample for one move under the current window.
  function automatic cti_out_t calc_sample(cti_in_t mv);
    logic [127:0]       tau, t2, s, pmag, g, w, vq, vlim;
    logic [32:0]        dur, el;
    logic signed [33:0] delta, posw;
    logic [33:0]        mag;
    logic               neg;
    cti_out_t           r;
    r.position_out  = mv.from_position;
    r.velocity_out  = '0;
    r.window_status = ST_EMPTY;
    if (win_end <= win_start) return r;
    dur = {1'b0, win_end} - {1'b0, win_start};
    if (mv.now_time < win_start) begin
      el = '0;
      r.window_status = ST_BEFORE;
    end else if (mv.now_time > win_end) begin
      el = dur;
      r.window_status = ST_AFTER;
    end else begin
      el = {1'b0, mv.now_time} - {1'b0, win_start};
      r.window_status = ST_INSIDE;
    end
    delta = {{2{mv.to_position[31]}}, mv.to_position}
          - {{2{mv.from_position[31]}}, mv.from_position};
    neg = delta[33];
    mag = neg ? -delta : delta;
    tau = (128'(el) << TAU_F) / 128'(dur);
    t2  = (tau * tau) >> TAU_F;
    s   = (t2 * ((128'd3 << TAU_F) - 2 * tau)) >> TAU_F;
    // blended position always lies between the endpoints
    pmag = (128'(mag) * s) >> TAU_F;
    posw = {{2{mv.from_position[31]}}, mv.from_position};
    posw = neg ? posw - $signed(pmag[33:0]) : posw + $signed(pmag[33:0]);
    r.position_out = posw[31:0];
    // rate 6 tau (1 - tau) scaled to Q16.32 per tick, truncated toward zero
    g  = tau * ((128'd1 << TAU_F) - tau);
    w  = (3 * g) >> (TAU_F - 1);
    vq = ((128'(mag) * w) >> (TAU_F - 16)) / 128'(dur);
    vlim = 128'h7FFF_FFFF_FFFF + (neg ? 128'd1 : 128'd0);
    if (vq > vlim) vq = vlim;
    r.velocity_out = neg ? -vq[47:0] : vq[47:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [31:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cti_in_t rand_move();
    cti_in_t mv;
    int      r;
    r = $urandom_range(0, 19);
    if (r == 0) mv.now_time = win_start;
    else if (r == 1) mv.now_time = win_end;
    else if (r == 2) mv.now_time = win_start - 1;
    else if (r == 3) mv.now_time = win_end + 1;
    else if (r < 7) mv.now_time = $urandom;
    else if (win_end > win_start)
      mv.now_time = win_start + ($urandom % (win_end - win_start + 33'd1));
    else mv.now_time = $urandom;
    mv.from_position = pick_pos();
    mv.to_position   = pick_pos();
    return mv;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // Register write; bench copy follows at the same edge as the block.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_START_TIME) win_start = val;
    else if (idx == REG_END_TIME) win_end = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (move_q.size() != 0 || in_valid || sample_q.size() != 0);
    // let the pipeline settle before touching the registers
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_window(logic [31:0] st, logic [31:0] en);
    write_reg(REG_START_TIME, st);
    write_reg(REG_END_TIME, en);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) move_q.push_back(rand_move());
  endtask

  task automatic queue_move(logic [31:0] t, logic [31:0] a, logic [31:0] b);
    cti_in_t mv;
    mv.now_time = t;
    mv.from_position = a;
    mv.to_position = b;
    move_q.push_back(mv);
  endtask

  // Driver: expectation is recorded when the block takes a transaction.
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) sample_q.push_back(calc_sample(in_data));
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (move_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= move_q.pop_front();
        in_gap   = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result and drives the output stall.
  always @(posedge clk) begin
    cti_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          report("unexpected result", 64'(out_data), 64'd0);
        end else begin
          want = sample_q.pop_front();
          if (out_data.position_out !== want.position_out)
            report("position_out", 64'(out_data.position_out), 64'(want.position_out));
          if (out_data.velocity_out !== want.velocity_out)
            report("velocity_out", 64'(out_data.velocity_out), 64'(want.velocity_out));
          if (out_data.window_status !== want.window_status)
            report("window_status", 64'(out_data.window_status), 64'(want.window_status));
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall <= (out_gap > 0);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0] st;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset window 0..1, no register writes yet
    queue_move(32'd0, 32'h0001_0000, 32'h0003_0000);
    queue_move(32'd1, 32'h0001_0000, 32'h0003_0000);
    queue_random(60);
    wait_drained();

    // directed: window edges, clamping, endpoint extremes
    set_window(32'd100, 32'd1100);
    queue_move(32'd0,          32'h8000_0000, 32'h7FFF_FFFF);
    queue_move(32'd99,         32'h7FFF_FFFF, 32'h8000_0000);
    queue_move(32'd100,        32'h8000_0000, 32'h7FFF_FFFF);
    queue_move(32'd350,        32'h8000_0000, 32'h7FFF_FFFF);
    queue_move(32'd600,        32'h7FFF_FFFF, 32'h8000_0000);
    queue_move(32'd850,        32'hFFFF_FFFF, 32'h0000_0000);
    queue_move(32'd1100,       32'h7FFF_FFFF, 32'h8000_0000);
    queue_move(32'd1101,       32'h0001_0000, 32'hFFFF_0000);
    queue_move(32'hFFFF_FFFF,  32'h1234_5678, 32'h1234_5678);
    queue_move(32'd600,        32'h0000_0000, 32'h0000_0000);
    queue_move(32'd101,        32'h8000_0000, 32'h7FFF_FFFF);
    queue_move(32'd1099,       32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(180);
    wait_drained();

    // full-range window; unused register indexes must be ignored
    set_window(32'd0, 32'hFFFF_FFFF);
    write_reg(2'd2, 32'h5555_5555);
    write_reg(2'd3, 32'hAAAA_AAAA);
    queue_random(200);
    wait_drained();

    // one-tick window at the top of the range: tau is only 0 or 1, so velocity is zero
    set_window(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_random(150);
    wait_drained();

    // empty windows
    set_window(32'd5000, 32'd5000);
    queue_random(60);
    wait_drained();
    set_window(32'hFFFF_FFFF, 32'd0);
    queue_random(60);
    wait_drained();

    // long receiver hold-off: pipeline fills and the input stalls
    st = $urandom;
    set_window(st >> 1, (st >> 1) + $urandom_range(2, 5000));
    idle_on = 1'b0;
    queue_random(300);
    hold_req++;
    // sender pauses until everything is back, then continues
    do @(posedge clk); while (move_q.size() != 0 || in_valid || sample_q.size() != 0);
    idle_on = 1'b1;
    queue_random(120);
    wait_drained();

    // a few random windows, mostly short
    for (int k = 0; k < 4; k++) begin
      st = $urandom;
      set_window(st, (k == 3) ? $urandom : st + $urandom_range(1, 1 << (4 * k + 4)));
      queue_random(80);
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: cubic_trajectory_interpolator_top.f
hw/rtl/cti_pkg.sv
hw/rtl/cti_div_pipe.sv
hw/rtl/cubic_trajectory_interpolator_top.sv
verif/tb_top.sv
